// ===== design/tito_pkg.sv =====
`timescale 1ns / 1ps

package tito_pkg;

    localparam int NUM_DIMS  = 4;
    localparam int DIM_W     = 2;
    localparam int RANK_W    = 3;
    localparam int SIZE_W    = 13;
    localparam int LAYOUT_W  = NUM_DIMS * DIM_W;
    localparam int OFFSET_W  = 48;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [RANK_W-1:0]   RANK_RESET   = RANK_W'(4);
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(1);
    localparam logic [LAYOUT_W-1:0] LAYOUT_RESET = LAYOUT_W'(27);

    // Register map, word index = paddr[4:2]
    typedef enum logic [REG_IDX_W-1:0] {
        REG_RANK       = 3'd0,
        REG_DIM_SIZE_0 = 3'd1,
        REG_DIM_SIZE_1 = 3'd2,
        REG_DIM_SIZE_2 = 3'd3,
        REG_DIM_SIZE_3 = 3'd4,
        REG_LAYOUT     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [RANK_W-1:0]                rank;
        logic [NUM_DIMS-1:0][SIZE_W-1:0]  dim_size;
        logic [LAYOUT_W-1:0]              layout;
    } cfg_t;

endpackage

// ===== design/tito_in_if.sv =====
`timescale 1ns / 1ps

interface tito_in_if #(
    parameter int INDEX_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index_0;
    logic [INDEX_BITS-1:0] index_1;
    logic [INDEX_BITS-1:0] index_2;
    logic [INDEX_BITS-1:0] index_3;

    modport source (output valid, index_0, index_1, index_2, index_3, input ready);
    modport sink   (input valid, index_0, index_1, index_2, index_3, output ready);
endinterface

// ===== design/tito_out_if.sv =====
`timescale 1ns / 1ps

interface tito_out_if;
    import tito_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] offset;
    logic                out_of_range;

    modport source (output valid, offset, out_of_range, input ready);
    modport sink   (input valid, offset, out_of_range, output ready);
endinterface

// ===== design/tensor_index_to_offset_unit.sv =====
`timescale 1ns / 1ps

// Pipeline: four register stages; a word accepted into the select register moves
//   through the two multiply-add registers to the output register, which offers it on result_ch.
// Throughput: one word per cycle while result_ch takes results, set by one multiply-add per layout entry
//   in each of the three arithmetic stages.
// Reset (rst_n, async, active low): empties the pipeline and loads rank 4,
//   every extent 1 and layout order 3,2,1,0.
module tensor_index_to_offset_unit #(
    parameter int MAX_RANK   = 4,
    parameter int INDEX_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Index words in, offset words out
    tito_in_if.sink                      index_ch,
    tito_out_if.source                   result_ch,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tito_pkg::ADDR_W-1:0]  paddr,
    input  logic [tito_pkg::DATA_W-1:0]  pwdata,
    output logic [tito_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import tito_pkg::*;

    // Running scale after entries 0..k-1 is a product of k extents.
    localparam int SC1_W  = SIZE_W;
    localparam int SC2_W  = 2 * SIZE_W;
    localparam int SC3_W  = 3 * SIZE_W;
    // Partial offsets grow by one extent and one carry per entry; clip at 48.
    localparam int OFF1_W = INDEX_BITS;
    localparam int OFF2_W = (SIZE_W + INDEX_BITS + 1 > OFFSET_W) ?
                            OFFSET_W : SIZE_W + INDEX_BITS + 1;
    localparam int OFF3_W = (2 * SIZE_W + INDEX_BITS + 1 > OFFSET_W) ?
                            OFFSET_W : 2 * SIZE_W + INDEX_BITS + 1;
    // Side payload carried past each arithmetic stage
    localparam int PASS2_W = 1 + SIZE_W + 2 * INDEX_BITS;
    localparam int PASS3_W = 1 + INDEX_BITS;

    cfg_t                  cfg;

    logic [INDEX_BITS-1:0] idx_in   [NUM_DIMS];
    logic [INDEX_BITS-1:0] ent_idx  [NUM_DIMS];
    logic [SIZE_W-1:0]     ent_size [NUM_DIMS-1];
    logic                  s1_valid;
    logic                  s1_ready;
    logic                  s1_bad;

    logic                  s2_valid;
    logic                  s2_ready;
    logic [OFF2_W-1:0]     s2_off;
    logic [SC2_W-1:0]      s2_scale;
    logic [PASS2_W-1:0]    s2_pass_in;
    logic [PASS2_W-1:0]    s2_pass;

    logic                  s3_valid;
    logic                  s3_ready;
    logic [OFF3_W-1:0]     s3_off;
    logic [SC3_W-1:0]      s3_scale;
    logic [PASS3_W-1:0]    s3_pass_in;
    logic [PASS3_W-1:0]    s3_pass;

    logic                  s4_ready;

    tito_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign idx_in[0] = index_ch.index_0;
    assign idx_in[1] = index_ch.index_1;
    assign idx_in[2] = index_ch.index_2;
    assign idx_in[3] = index_ch.index_3;

    // Stage 1: resolve layout entries to index/extent pairs, flag range errors.
    // Entry 0 has scale 1, so its index is the first partial offset and its
    // extent the next scale.
    tito_select #(
        .INDEX_BITS (INDEX_BITS),
        .MAX_RANK   (MAX_RANK)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .valid_in  (index_ch.valid),
        .ready_out (index_ch.ready),
        .idx_in    (idx_in),
        .valid_out (s1_valid),
        .ready_in  (s1_ready),
        .ent_idx   (ent_idx),
        .ent_size  (ent_size),
        .bad_out   (s1_bad)
    );

    // Stage 2: entry 1
    assign s2_pass_in = {s1_bad, ent_size[2], ent_idx[3], ent_idx[2]};

    tito_mac_stage #(
        .IDX_W       (INDEX_BITS),
        .SIZE_IN_W   (SIZE_W),
        .SCALE_IN_W  (SC1_W),
        .SCALE_OUT_W (SC2_W),
        .OFF_IN_W    (OFF1_W),
        .OFF_OUT_W   (OFF2_W),
        .PASS_W      (PASS2_W)
    ) u_mac1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .ready_out (s1_ready),
        .off_in    (ent_idx[0]),
        .scale_in  (ent_size[0]),
        .idx_in    (ent_idx[1]),
        .size_in   (ent_size[1]),
        .pass_in   (s2_pass_in),
        .valid_out (s2_valid),
        .ready_in  (s2_ready),
        .off_out   (s2_off),
        .scale_out (s2_scale),
        .pass_out  (s2_pass)
    );

    // Stage 3: entry 2; s2_pass = {bad, extent 2, index 3, index 2}
    assign s3_pass_in = {s2_pass[PASS2_W-1], s2_pass[2*INDEX_BITS-1:INDEX_BITS]};

    tito_mac_stage #(
        .IDX_W       (INDEX_BITS),
        .SIZE_IN_W   (SIZE_W),
        .SCALE_IN_W  (SC2_W),
        .SCALE_OUT_W (SC3_W),
        .OFF_IN_W    (OFF2_W),
        .OFF_OUT_W   (OFF3_W),
        .PASS_W      (PASS3_W)
    ) u_mac2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .ready_out (s2_ready),
        .off_in    (s2_off),
        .scale_in  (s2_scale),
        .idx_in    (s2_pass[INDEX_BITS-1:0]),
        .size_in   (s2_pass[PASS2_W-2:2*INDEX_BITS]),
        .pass_in   (s3_pass_in),
        .valid_out (s3_valid),
        .ready_in  (s3_ready),
        .off_out   (s3_off),
        .scale_out (s3_scale),
        .pass_out  (s3_pass)
    );

    // Stage 4: entry 3 and the output register; s3_pass = {bad, index 3}
    tito_out_stage #(
        .IDX_W      (INDEX_BITS),
        .SCALE_IN_W (SC3_W),
        .OFF_IN_W   (OFF3_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s3_valid),
        .ready_out (s4_ready),
        .off_in    (s3_off),
        .scale_in  (s3_scale),
        .idx_in    (s3_pass[INDEX_BITS-1:0]),
        .bad_in    (s3_pass[PASS3_W-1]),
        .result_ch (result_ch)
    );

    assign s3_ready = s4_ready;

endmodule

// ===== design/tito_cfg_regs.sv =====
`timescale 1ns / 1ps

module tito_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tito_pkg::ADDR_W-1:0]  paddr,
    input  logic [tito_pkg::DATA_W-1:0]  pwdata,
    output logic [tito_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tito_pkg::cfg_t               cfg
);
    import tito_pkg::*;

    logic [RANK_W-1:0]               rank_reg;
    logic [RANK_W-1:0]               rank_next;
    logic [NUM_DIMS-1:0][SIZE_W-1:0] dim_size_reg;
    logic [NUM_DIMS-1:0][SIZE_W-1:0] dim_size_next;
    logic [LAYOUT_W-1:0]             layout_reg;
    logic [LAYOUT_W-1:0]             layout_next;
    logic                            wr_en;
    reg_idx_t                        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        rank_next     = rank_reg;
        dim_size_next = dim_size_reg;
        layout_next   = layout_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_RANK:       rank_next        = pwdata[RANK_W-1:0];
                REG_DIM_SIZE_0: dim_size_next[0] = pwdata[SIZE_W-1:0];
                REG_DIM_SIZE_1: dim_size_next[1] = pwdata[SIZE_W-1:0];
                REG_DIM_SIZE_2: dim_size_next[2] = pwdata[SIZE_W-1:0];
                REG_DIM_SIZE_3: dim_size_next[3] = pwdata[SIZE_W-1:0];
                REG_LAYOUT:     layout_next      = pwdata[LAYOUT_W-1:0];
                default:        ;   // unmapped word: drop the write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg     <= RANK_RESET;
            dim_size_reg <= {NUM_DIMS{SIZE_RESET}};
            layout_reg   <= LAYOUT_RESET;
        end
        else
        begin
            rank_reg     <= rank_next;
            dim_size_reg <= dim_size_next;
            layout_reg   <= layout_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RANK:       prdata = DATA_W'(rank_reg);
            REG_DIM_SIZE_0: prdata = DATA_W'(dim_size_reg[0]);
            REG_DIM_SIZE_1: prdata = DATA_W'(dim_size_reg[1]);
            REG_DIM_SIZE_2: prdata = DATA_W'(dim_size_reg[2]);
            REG_DIM_SIZE_3: prdata = DATA_W'(dim_size_reg[3]);
            REG_LAYOUT:     prdata = DATA_W'(layout_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.rank     = rank_reg;
    assign cfg.dim_size = dim_size_reg;
    assign cfg.layout   = layout_reg;

endmodule

// ===== design/tito_select.sv =====
`timescale 1ns / 1ps

module tito_select #(
    parameter int INDEX_BITS = 12,
    parameter int MAX_RANK   = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tito_pkg::cfg_t                cfg,
    input  logic                          valid_in,
    output logic                          ready_out,
    input  logic [INDEX_BITS-1:0]         idx_in   [tito_pkg::NUM_DIMS],
    output logic                          valid_out,
    input  logic                          ready_in,
    output logic [INDEX_BITS-1:0]         ent_idx  [tito_pkg::NUM_DIMS],
    output logic [tito_pkg::SIZE_W-1:0]   ent_size [tito_pkg::NUM_DIMS-1],
    output logic                          bad_out
);
    import tito_pkg::*;

    localparam int EFF_CAP = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
    localparam int CMP_W   = (INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W;

    logic                  valid_reg;
    logic                  advance;
    logic [RANK_W-1:0]     eff_rank;
    logic [INDEX_BITS-1:0] idx_next  [NUM_DIMS];
    logic [SIZE_W-1:0]     size_next [NUM_DIMS-1];
    logic                  bad_next;
    logic [INDEX_BITS-1:0] idx_reg   [NUM_DIMS];
    logic [SIZE_W-1:0]     size_reg  [NUM_DIMS-1];
    logic                  bad_reg;

    assign advance   = !valid_reg || ready_in;
    assign ready_out = advance;
    assign eff_rank  = (cfg.rank > RANK_W'(EFF_CAP)) ? RANK_W'(EFF_CAP) : cfg.rank;

    // Map layout entries to (index, extent) pairs; unused entries become (0, 1)
    always_comb
    begin
        logic [DIM_W-1:0] dim;
        logic             used;
        bad_next = 1'b0;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            if ((RANK_W'(d) < eff_rank) &&
                (CMP_W'(idx_in[d]) >= CMP_W'(cfg.dim_size[d])))
                bad_next = 1'b1;
        end
        for (int k = 0; k < NUM_DIMS; k++)
        begin
            dim  = cfg.layout[k*DIM_W +: DIM_W];
            used = RANK_W'(k) < eff_rank;
            if (used && (RANK_W'(dim) >= eff_rank))
                bad_next = 1'b1;
            idx_next[k] = used ? idx_in[dim] : '0;
            // the last entry's extent never feeds a later scale
            if (k < NUM_DIMS-1)
                size_next[k] = used ? cfg.dim_size[dim] : SIZE_RESET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            idx_reg  <= idx_next;
            size_reg <= size_next;
            bad_reg  <= bad_next;
        end
    end

    assign valid_out = valid_reg;
    assign ent_idx   = idx_reg;
    assign ent_size  = size_reg;
    assign bad_out   = bad_reg;

endmodule

// ===== design/tito_mac_stage.sv =====
`timescale 1ns / 1ps

module tito_mac_stage #(
    parameter int IDX_W       = 12,
    parameter int SIZE_IN_W   = 13,
    parameter int SCALE_IN_W  = 13,
    parameter int SCALE_OUT_W = 26,
    parameter int OFF_IN_W    = 12,
    parameter int OFF_OUT_W   = 26,
    parameter int PASS_W      = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    output logic                   ready_out,
    input  logic [OFF_IN_W-1:0]    off_in,
    input  logic [SCALE_IN_W-1:0]  scale_in,
    input  logic [IDX_W-1:0]       idx_in,
    input  logic [SIZE_IN_W-1:0]   size_in,
    input  logic [PASS_W-1:0]      pass_in,
    output logic                   valid_out,
    input  logic                   ready_in,
    output logic [OFF_OUT_W-1:0]   off_out,
    output logic [SCALE_OUT_W-1:0] scale_out,
    output logic [PASS_W-1:0]      pass_out
);

    localparam int PROD_W = SCALE_IN_W + IDX_W;
    localparam int SPRD_W = SCALE_IN_W + SIZE_IN_W;

    logic                   valid_reg;
    logic                   advance;
    logic [PROD_W-1:0]      prod;
    logic [SPRD_W-1:0]      scale_prod;
    logic [OFF_OUT_W-1:0]   off_next;
    logic [SCALE_OUT_W-1:0] scale_next;
    logic [OFF_OUT_W-1:0]   off_reg;
    logic [SCALE_OUT_W-1:0] scale_reg;
    logic [PASS_W-1:0]      pass_reg;

    assign advance    = !valid_reg || ready_in;
    assign ready_out  = advance;

    // Accumulate this entry's term and extend the running scale
    assign prod       = PROD_W'(scale_in) * PROD_W'(idx_in);
    assign scale_prod = SPRD_W'(scale_in) * SPRD_W'(size_in);
    assign off_next   = OFF_OUT_W'(off_in) + OFF_OUT_W'(prod);
    assign scale_next = SCALE_OUT_W'(scale_prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            off_reg   <= off_next;
            scale_reg <= scale_next;
            pass_reg  <= pass_in;
        end
    end

    assign valid_out = valid_reg;
    assign off_out   = off_reg;
    assign scale_out = scale_reg;
    assign pass_out  = pass_reg;

endmodule

// ===== design/tito_out_stage.sv =====
`timescale 1ns / 1ps

module tito_out_stage #(
    parameter int IDX_W      = 12,
    parameter int SCALE_IN_W = 39,
    parameter int OFF_IN_W   = 39
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    output logic                  ready_out,
    input  logic [OFF_IN_W-1:0]   off_in,
    input  logic [SCALE_IN_W-1:0] scale_in,
    input  logic [IDX_W-1:0]      idx_in,
    input  logic                  bad_in,
    tito_out_if.source            result_ch
);
    import tito_pkg::*;

    localparam int PROD_W = SCALE_IN_W + IDX_W;

    logic                valid_reg;
    logic                advance;
    logic [PROD_W-1:0]   prod;
    logic [OFFSET_W-1:0] offset_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic                oor_reg;

    assign advance     = !valid_reg || result_ch.ready;
    assign ready_out   = advance;
    assign prod        = PROD_W'(scale_in) * PROD_W'(idx_in);
    // Wrap modulo 2^48
    assign offset_next = OFFSET_W'(off_in) + OFFSET_W'(prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            offset_reg <= offset_next;
            oor_reg    <= bad_in;
        end
    end

    assign result_ch.valid        = valid_reg;
    assign result_ch.offset       = offset_reg;
    assign result_ch.out_of_range = oor_reg;

endmodule

// ===== design/tito_checker.sv =====
`timescale 1ns / 1ps

module tito_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [tito_pkg::OFFSET_W-1:0] offset,
    input  logic                          out_of_range
);
    import tito_pkg::*;

    localparam int DEPTH = 4;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
            count_next = count_reg + 3'd1;
        else if (out_acc && !in_acc)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Hold a stalled word
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(offset) && $stable(out_of_range))
        else $error("result payload changed while stalled");

    // No result without a word in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 3'd0)
        else $error("result offered with nothing in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH))
        else $error("more words in flight than pipeline stages");

    // Empty output register means nothing blocks the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register empty");

endmodule

bind tensor_index_to_offset_unit tito_checker u_tito_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (index_ch.valid),
    .in_ready     (index_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .offset       (result_ch.offset),
    .out_of_range (result_ch.out_of_range)
);
